// ----- src/plsm_pkg.sv -----
// Shared types and constants of the packet latency statistics monitor.
`timescale 1ns / 1ps
`default_nettype none

package plsm_pkg;

  // Fixed field widths
  localparam int TS_W  = 64;  // timestamp width
  localparam int SUM_W = 64;  // running sum width
  localparam int CNT_W = 32;  // sample counter width
  localparam int OUT_W = 32;  // result field width
  localparam int CLS_W = 3;   // class index width
  localparam int QCL_W = 2;   // queue class index width

  localparam int NUM_CLASSES  = 6;
  localparam int NUM_QCLASSES = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Opcodes
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Upstream packet kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;

  // Packet classes
  localparam logic [CLS_W-1:0] CLS_DATA_UP   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_CLOSE_UP  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_OPEN_UP   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_DATA_DOWN = 3'd3;
  localparam logic [CLS_W-1:0] CLS_POOL_UP   = 3'd4;
  localparam logic [CLS_W-1:0] CLS_POOL_DOWN = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the incoming transaction
    logic upd_main;   // update the packet class
    logic upd_pool;   // update the pool class
    logic clear;      // clear all statistics
    logic div_start;  // launch the average dividers
    logic res_load;   // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pool_en;    // pool statistics enabled
    logic div_done;   // quotients ready
  } sts_t;

endpackage

`default_nettype wire

// ----- src/plsm_div.sv -----
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
`default_nettype none

module plsm_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [plsm_pkg::SUM_W-1:0]     dividend,
  input  wire logic [plsm_pkg::CNT_W-1:0]     divisor,
  output logic                                done,
  output logic [plsm_pkg::SUM_W-1:0]          quotient
);

  localparam int SW   = plsm_pkg::SUM_W;
  localparam int CW   = plsm_pkg::CNT_W;
  localparam int STPW = $clog2(SW);

  logic [SW-1:0]   quo_r, quo_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   dsr_r;
  logic [STPW-1:0] stp_r;
  logic            busy_r;
  logic            done_r;
  logic [CW:0]     trial;
  logic [CW:0]     diff;
  logic            ge;

  // One quotient bit a cycle, dividend shifts out as quotient shifts in
  always_comb begin
    trial   = {rem_r, quo_r[SW-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = (trial >= {1'b0, dsr_r});
    rem_nxt = ge ? diff[CW-1:0] : trial[CW-1:0];
    quo_nxt = {quo_r[SW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      stp_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        stp_r  <= '0;
      end else if (busy_r) begin
        stp_r <= stp_r + 1'b1;
        if (stp_r == STPW'(SW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- src/plsm_dpath.sv -----
// Datapath: statistics registers, elapsed time arithmetic, dividers and result register.
`timescale 1ns / 1ps
`default_nettype none

module plsm_dpath #(
  parameter int ELAPSED_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire plsm_pkg::cmd_t                cmd,
  output plsm_pkg::sts_t                     sts,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic                          in_upstream,
  input  wire logic [1:0]                    in_packet_kind,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_proc_start_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_proc_end_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_queue_start_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_queue_end_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_pool_in_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_pool_out_time,
  input  wire logic [plsm_pkg::CLS_W-1:0]    in_read_class,
  output logic [plsm_pkg::OUT_W-1:0]         out_sample_count,
  output logic [plsm_pkg::OUT_W-1:0]         out_min_total,
  output logic [plsm_pkg::OUT_W-1:0]         out_max_total,
  output logic [plsm_pkg::OUT_W-1:0]         out_avg_total,
  output logic [plsm_pkg::OUT_W-1:0]         out_min_queue,
  output logic [plsm_pkg::OUT_W-1:0]         out_max_queue,
  output logic [plsm_pkg::OUT_W-1:0]         out_avg_queue
);

  localparam int EW  = ELAPSED_WIDTH;
  localparam int SW  = plsm_pkg::SUM_W;
  localparam int CW  = plsm_pkg::CNT_W;
  localparam int OW  = plsm_pkg::OUT_W;
  localparam int TW  = plsm_pkg::TS_W;
  localparam int LW  = plsm_pkg::CLS_W;
  localparam int QW  = plsm_pkg::QCL_W;
  localparam int NC  = plsm_pkg::NUM_CLASSES;
  localparam int NQ  = plsm_pkg::NUM_QCLASSES;
  localparam logic [SW-1:0] EL_MASK =
    (EW >= SW) ? {SW{1'b1}} : ((SW'(1) << EW) - SW'(1));

  // Statistics store
  logic [CW-1:0] cnt_r  [NC];
  logic [SW-1:0] tsum_r [NC];
  logic [EW-1:0] tmin_r [NC];
  logic [EW-1:0] tmax_r [NC];
  logic [SW-1:0] qsum_r [NQ];
  logic [EW-1:0] qmin_r [NQ];
  logic [EW-1:0] qmax_r [NQ];

  logic          pool_en_r;

  // Captured transaction
  logic [1:0]    op_r;
  logic [LW-1:0] mcls_r;
  logic [LW-1:0] pcls_r;
  logic [LW-1:0] rc_r;
  logic [EW-1:0] el_tot_r;
  logic [EW-1:0] el_q_r;
  logic [EW-1:0] el_pool_r;

  logic [OW-1:0] cnt_o_r, tmin_o_r, tmax_o_r, tavg_o_r, qmin_o_r, qmax_o_r, qavg_o_r;

  logic [TW-1:0] d_tot, d_q, d_pool;
  logic [LW-1:0] mcls_nxt;

  logic [LW-1:0] ucls;
  logic [QW-1:0] uq;
  logic [EW-1:0] uval;
  logic [CW-1:0] cnt_nxt;
  logic [SW:0]   tsum_add, qsum_add;
  logic [SW-1:0] tsum_nxt, qsum_nxt;
  logic [EW-1:0] tmin_nxt, tmax_nxt, qmin_nxt, qmax_nxt;

  logic          rc_ok, rq_ok;
  logic [LW-1:0] ridx;
  logic [QW-1:0] rq;
  logic          tdiv_done, qdiv_done;
  logic [SW-1:0] tquo, qquo;

  function automatic logic [OW-1:0] avg_sat(input logic [SW-1:0] q, input logic [CW-1:0] n);
    logic [SW-1:0] s;
    begin
      s       = (q > EL_MASK) ? EL_MASK : q;
      avg_sat = (n == '0) ? '0 : s[OW-1:0];
    end
  endfunction

  // Elapsed times and class of the incoming sample
  always_comb begin
    d_tot  = in_proc_end_time - in_proc_start_time;
    d_q    = in_queue_end_time - in_queue_start_time;
    d_pool = in_pool_out_time - in_pool_in_time;
    if (!in_upstream) begin
      mcls_nxt = plsm_pkg::CLS_DATA_DOWN;
    end else if (in_packet_kind == plsm_pkg::KIND_DATA) begin
      mcls_nxt = plsm_pkg::CLS_DATA_UP;
    end else if (in_packet_kind == plsm_pkg::KIND_CLOSE) begin
      mcls_nxt = plsm_pkg::CLS_CLOSE_UP;
    end else begin
      mcls_nxt = plsm_pkg::CLS_OPEN_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      mcls_r    <= mcls_nxt;
      pcls_r    <= in_upstream ? plsm_pkg::CLS_POOL_UP : plsm_pkg::CLS_POOL_DOWN;
      rc_r      <= in_read_class;
      el_tot_r  <= d_tot[EW-1:0];
      el_q_r    <= d_q[EW-1:0];
      el_pool_r <= d_pool[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      pool_en_r <= cfg_wr_data;
    end
  end

  // Update step: one class a cycle
  always_comb begin
    ucls     = cmd.upd_pool ? pcls_r : mcls_r;
    uq       = mcls_r[QW-1:0];
    uval     = cmd.upd_pool ? el_pool_r : el_tot_r;
    cnt_nxt  = (cnt_r[ucls] == plsm_pkg::COUNT_MAX) ? cnt_r[ucls] : cnt_r[ucls] + 1'b1;
    tsum_add = {1'b0, tsum_r[ucls]} + {1'b0, SW'(uval)};
    tsum_nxt = tsum_add[SW] ? {SW{1'b1}} : tsum_add[SW-1:0];
    tmin_nxt = (uval < tmin_r[ucls]) ? uval : tmin_r[ucls];
    tmax_nxt = (uval > tmax_r[ucls]) ? uval : tmax_r[ucls];
    qsum_add = {1'b0, qsum_r[uq]} + {1'b0, SW'(el_q_r)};
    qsum_nxt = qsum_add[SW] ? {SW{1'b1}} : qsum_add[SW-1:0];
    qmin_nxt = (el_q_r < qmin_r[uq]) ? el_q_r : qmin_r[uq];
    qmax_nxt = (el_q_r > qmax_r[uq]) ? el_q_r : qmax_r[uq];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < NC; i++) begin
        cnt_r[i]  <= '0;
        tsum_r[i] <= '0;
        tmin_r[i] <= '1;
        tmax_r[i] <= '0;
      end
      for (int i = 0; i < NQ; i++) begin
        qsum_r[i] <= '0;
        qmin_r[i] <= '1;
        qmax_r[i] <= '0;
      end
    end else begin
      if (cmd.upd_main || cmd.upd_pool) begin
        cnt_r[ucls]  <= cnt_nxt;
        tsum_r[ucls] <= tsum_nxt;
        tmin_r[ucls] <= tmin_nxt;
        tmax_r[ucls] <= tmax_nxt;
      end
      if (cmd.upd_main) begin
        qsum_r[uq] <= qsum_nxt;
        qmin_r[uq] <= qmin_nxt;
        qmax_r[uq] <= qmax_nxt;
      end
    end
  end

  // Read path
  always_comb begin
    rc_ok = (rc_r < LW'(NC));
    rq_ok = (rc_r < LW'(NQ));
    ridx  = rc_ok ? rc_r : '0;
    rq    = rc_r[QW-1:0];
  end

  plsm_div u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tsum_r[ridx]),
    .divisor  (cnt_r[ridx]),
    .done     (tdiv_done),
    .quotient (tquo)
  );

  plsm_div u_qdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (qsum_r[rq]),
    .divisor  (cnt_r[ridx]),
    .done     (qdiv_done),
    .quotient (qquo)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      cnt_o_r  <= '0;
      tmin_o_r <= '0;
      tmax_o_r <= '0;
      tavg_o_r <= '0;
      qmin_o_r <= '0;
      qmax_o_r <= '0;
      qavg_o_r <= '0;
      if (op_r == plsm_pkg::OP_READ && rc_ok) begin
        cnt_o_r  <= OW'(cnt_r[ridx]);
        tmin_o_r <= OW'(tmin_r[ridx]);
        tmax_o_r <= OW'(tmax_r[ridx]);
        tavg_o_r <= avg_sat(tquo, cnt_r[ridx]);
        if (rq_ok) begin
          qmin_o_r <= OW'(qmin_r[rq]);
          qmax_o_r <= OW'(qmax_r[rq]);
          qavg_o_r <= avg_sat(qquo, cnt_r[ridx]);
        end
      end
    end
  end

  assign sts = '{pool_en: pool_en_r, div_done: tdiv_done & qdiv_done};

  assign out_sample_count = cnt_o_r;
  assign out_min_total    = tmin_o_r;
  assign out_max_total    = tmax_o_r;
  assign out_avg_total    = tavg_o_r;
  assign out_min_queue    = qmin_o_r;
  assign out_max_queue    = qmax_o_r;
  assign out_avg_queue    = qavg_o_r;

endmodule

`default_nettype wire

// ----- src/plsm_ctrl.sv -----
// Controller: sequences record, read and clear transactions and the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module plsm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_opcode,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire plsm_pkg::sts_t sts,
  output plsm_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD_MAIN,
    S_UPD_POOL,
    S_CLEAR,
    S_RD_START,
    S_RD_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   res_free;

  always_comb begin
    res_free      = !out_valid_r || !out_stall;
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          case (in_opcode)
            plsm_pkg::OP_RECORD: state_nxt = S_UPD_MAIN;
            plsm_pkg::OP_READ:   state_nxt = S_RD_START;
            plsm_pkg::OP_CLEAR:  state_nxt = S_CLEAR;
            default:             state_nxt = S_DONE;
          endcase
        end
      end
      S_UPD_MAIN: begin
        cmd.upd_main = 1'b1;
        state_nxt    = sts.pool_en ? S_UPD_POOL : S_DONE;
      end
      S_UPD_POOL: begin
        cmd.upd_pool = 1'b1;
        state_nxt    = S_DONE;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (res_free) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- src/packet_latency_stats_monitor_core.sv -----
// Top level of the packet latency statistics monitor.
// Sequence: record updates the packet class, then the pool class with pool statistics on;
//   clear empties the store; unused opcode does nothing; read runs the 64-step average dividers.
// Throughput: one transaction at a time; the next is taken the cycle after the result is
//   loaded into the output register, which may still be waiting on out_stall.
// Reset (rst_n low, synchronous): all statistics cleared, minima all ones, pool stats off.
`timescale 1ns / 1ps
`default_nettype none

module packet_latency_stats_monitor_core #(
  parameter int ELAPSED_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic                          in_upstream,
  input  wire logic [1:0]                    in_packet_kind,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_proc_start_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_proc_end_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_queue_start_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_queue_end_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_pool_in_time,
  input  wire logic [plsm_pkg::TS_W-1:0]     in_pool_out_time,
  input  wire logic [plsm_pkg::CLS_W-1:0]    in_read_class,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [plsm_pkg::OUT_W-1:0]         out_sample_count,
  output logic [plsm_pkg::OUT_W-1:0]         out_min_total,
  output logic [plsm_pkg::OUT_W-1:0]         out_max_total,
  output logic [plsm_pkg::OUT_W-1:0]         out_avg_total,
  output logic [plsm_pkg::OUT_W-1:0]         out_min_queue,
  output logic [plsm_pkg::OUT_W-1:0]         out_max_queue,
  output logic [plsm_pkg::OUT_W-1:0]         out_avg_queue
);

  plsm_pkg::cmd_t cmd;
  plsm_pkg::sts_t sts;

  // Controller: one transaction in flight, result parked in the output register
  plsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: statistics store, elapsed time arithmetic, averaging dividers
  plsm_dpath #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_opcode           (in_opcode),
    .in_upstream         (in_upstream),
    .in_packet_kind      (in_packet_kind),
    .in_proc_start_time  (in_proc_start_time),
    .in_proc_end_time    (in_proc_end_time),
    .in_queue_start_time (in_queue_start_time),
    .in_queue_end_time   (in_queue_end_time),
    .in_pool_in_time     (in_pool_in_time),
    .in_pool_out_time    (in_pool_out_time),
    .in_read_class       (in_read_class),
    .out_sample_count    (out_sample_count),
    .out_min_total       (out_min_total),
    .out_max_total       (out_max_total),
    .out_avg_total       (out_avg_total),
    .out_min_queue       (out_min_queue),
    .out_max_queue       (out_max_queue),
    .out_avg_queue       (out_avg_queue)
  );

  // An accepted transaction always blocks the input on the next cycle
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after acceptance");

  // A new result only appears while a transaction is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced without a transaction in flight");

  // At most one datapath operation per cycle
  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.upd_main, cmd.upd_pool, cmd.clear, cmd.div_start, cmd.res_load}))
    else $error("conflicting datapath commands");

  // Divider completion only during a read in progress
  a_div_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> in_stall)
    else $error("divider completed while idle");

endmodule

`default_nettype wire

// ----- sim/packet_latency_stats_monitor_core_test.sv -----
// Self-checking testbench for the packet latency statistics monitor core.
`timescale 1ns / 1ps

module packet_latency_stats_monitor_core_test;

  localparam int TS_W         = plsm_pkg::TS_W;
  localparam int OUT_W        = plsm_pkg::OUT_W;
  localparam int CNT_W        = plsm_pkg::CNT_W;
  localparam int CLS_W        = plsm_pkg::CLS_W;
  localparam int QCL_W        = plsm_pkg::QCL_W;
  localparam int NUM_CLASSES  = plsm_pkg::NUM_CLASSES;
  localparam int NUM_QCLASSES = plsm_pkg::NUM_QCLASSES;

  localparam int ELAPSED_W    = 32;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_TICKS = 8;    // clear / record latency plus margin
  localparam int END_TICKS    = 80;   // longer than a read
  localparam int RANDOM_ITEMS = 1400;
  localparam int SEGMENTS     = 6;

  // Codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] KIND_OPEN   = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam logic [CLS_W-1:0] CLS_BAD_LO = 3'd6;
  localparam logic [CLS_W-1:0] CLS_BAD_HI = 3'd7;

  localparam logic [63:0] SPAN_MASK =
    (ELAPSED_W >= 64) ? {64{1'b1}} : ((64'd1 << ELAPSED_W) - 64'd1);
  localparam logic [OUT_W-1:0] EMPTY_MIN = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]       opcode;
    logic             upstream;
    logic [1:0]       packet_kind;
    logic [TS_W-1:0]  proc_start_time;
    logic [TS_W-1:0]  proc_end_time;
    logic [TS_W-1:0]  queue_start_time;
    logic [TS_W-1:0]  queue_end_time;
    logic [TS_W-1:0]  pool_in_time;
    logic [TS_W-1:0]  pool_out_time;
    logic [CLS_W-1:0] read_class;
  } stats_txn_t;

  typedef struct packed {
    logic [OUT_W-1:0] sample_count;
    logic [OUT_W-1:0] min_total;
    logic [OUT_W-1:0] max_total;
    logic [OUT_W-1:0] avg_total;
    logic [OUT_W-1:0] min_queue;
    logic [OUT_W-1:0] max_queue;
    logic [OUT_W-1:0] avg_queue;
  } stats_reply_t;

  typedef struct {
    bit           is_cfg;
    bit           cfg_val;
    stats_txn_t   txn;
    bit           fixed;   // expectation typed in, not predicted
    stats_reply_t want;
  } stim_row_t;

  // Block ports; the inputs driven here are known from time zero
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic             cfg_wr_data = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_opcode = '0;
  logic             in_upstream = 1'b0;
  logic [1:0]       in_packet_kind = '0;
  logic [TS_W-1:0]  in_proc_start_time = '0;
  logic [TS_W-1:0]  in_proc_end_time = '0;
  logic [TS_W-1:0]  in_queue_start_time = '0;
  logic [TS_W-1:0]  in_queue_end_time = '0;
  logic [TS_W-1:0]  in_pool_in_time = '0;
  logic [TS_W-1:0]  in_pool_out_time = '0;
  logic [CLS_W-1:0] in_read_class = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] out_sample_count;
  logic [OUT_W-1:0] out_min_total;
  logic [OUT_W-1:0] out_max_total;
  logic [OUT_W-1:0] out_avg_total;
  logic [OUT_W-1:0] out_min_queue;
  logic [OUT_W-1:0] out_max_queue;
  logic [OUT_W-1:0] out_avg_queue;

  // Shadow of the statistics store and the pool enable
  logic             pool_en_shadow;
  logic [CNT_W-1:0] cls_count [NUM_CLASSES];
  logic [63:0]      tot_sum   [NUM_CLASSES];
  logic [63:0]      tot_min   [NUM_CLASSES];
  logic [63:0]      tot_max   [NUM_CLASSES];
  logic [63:0]      q_sum     [NUM_QCLASSES];
  logic [63:0]      q_min     [NUM_QCLASSES];
  logic [63:0]      q_max     [NUM_QCLASSES];

  stats_reply_t replies_due [$];
  stim_row_t    stim_table [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 6;
  int           rx_idle_pct = 70;

  packet_latency_stats_monitor_core #(
    .ELAPSED_WIDTH(ELAPSED_W)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_upstream        (in_upstream),
    .in_packet_kind     (in_packet_kind),
    .in_proc_start_time (in_proc_start_time),
    .in_proc_end_time   (in_proc_end_time),
    .in_queue_start_time(in_queue_start_time),
    .in_queue_end_time  (in_queue_end_time),
    .in_pool_in_time    (in_pool_in_time),
    .in_pool_out_time   (in_pool_out_time),
    .in_read_class      (in_read_class),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample_count   (out_sample_count),
    .out_min_total      (out_min_total),
    .out_max_total      (out_max_total),
    .out_avg_total      (out_avg_total),
    .out_min_queue      (out_min_queue),
    .out_max_queue      (out_max_queue),
    .out_avg_queue      (out_avg_queue)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Low ELAPSED_W bits of the modular difference
  function automatic logic [63:0] span(logic [63:0] t_from, logic [63:0] t_to);
    return (t_to - t_from) & SPAN_MASK;
  endfunction

  function automatic void fold_sample(inout logic [63:0] sum, inout logic [63:0] lo,
                                      inout logic [63:0] hi, input logic [63:0] v);
    logic [64:0] wide;
    wide = {1'b0, sum} + {1'b0, v};
    sum = wide[64] ? {64{1'b1}} : wide[63:0];   // saturate the sum
    if (v > hi) hi = v;
    if (v < lo) lo = v;   // checked even when the sample also sets a new max
  endfunction

  function automatic void bump_class(logic [CLS_W-1:0] c, logic [63:0] v);
    if (cls_count[c] != plsm_pkg::COUNT_MAX) cls_count[c] = cls_count[c] + 1'b1;
    fold_sample(tot_sum[c], tot_min[c], tot_max[c], v);
  endfunction

  function automatic logic [63:0] mean(logic [63:0] sum, logic [CNT_W-1:0] n);
    logic [63:0] q;
    if (n == '0) return '0;
    q = sum / {32'd0, n};
    if (q > SPAN_MASK) q = SPAN_MASK;
    return q;
  endfunction

  function automatic void clear_stats();
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cls_count[i] = '0;
      tot_sum[i]   = '0;
      tot_min[i]   = SPAN_MASK;
      tot_max[i]   = '0;
    end
    for (int i = 0; i < NUM_QCLASSES; i++) begin
      q_sum[i] = '0;
      q_min[i] = SPAN_MASK;
      q_max[i] = '0;
    end
  endfunction

  // Apply one accepted transaction to the shadow and return the reply it owes
  function automatic stats_reply_t predict_reply(stats_txn_t t);
    stats_reply_t     r;
    logic [CLS_W-1:0] c;
    r = '0;
    case (t.opcode)
      plsm_pkg::OP_RECORD: begin
        // downstream is always data; the spare upstream kind folds into open
        if (!t.upstream) c = plsm_pkg::CLS_DATA_DOWN;
        else if (t.packet_kind == plsm_pkg::KIND_DATA) c = plsm_pkg::CLS_DATA_UP;
        else if (t.packet_kind == plsm_pkg::KIND_CLOSE) c = plsm_pkg::CLS_CLOSE_UP;
        else c = plsm_pkg::CLS_OPEN_UP;
        bump_class(c, span(t.proc_start_time, t.proc_end_time));
        fold_sample(q_sum[c[QCL_W-1:0]], q_min[c[QCL_W-1:0]], q_max[c[QCL_W-1:0]],
                    span(t.queue_start_time, t.queue_end_time));
        if (pool_en_shadow)
          bump_class(t.upstream ? plsm_pkg::CLS_POOL_UP : plsm_pkg::CLS_POOL_DOWN,
                     span(t.pool_in_time, t.pool_out_time));
      end
      plsm_pkg::OP_READ: begin
        if (t.read_class < CLS_W'(NUM_CLASSES)) begin
          c = t.read_class;
          r.sample_count = cls_count[c];
          r.min_total    = tot_min[c][OUT_W-1:0];
          r.max_total    = tot_max[c][OUT_W-1:0];
          r.avg_total    = OUT_W'(mean(tot_sum[c], cls_count[c]));
          if (c < CLS_W'(NUM_QCLASSES)) begin
            r.min_queue = q_min[c[QCL_W-1:0]][OUT_W-1:0];
            r.max_queue = q_max[c[QCL_W-1:0]][OUT_W-1:0];
            r.avg_queue = OUT_W'(mean(q_sum[c[QCL_W-1:0]], cls_count[c]));
          end
        end
      end
      plsm_pkg::OP_CLEAR: clear_stats();
      default: ;   // unused opcode leaves the store alone
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly short latencies, some long ones, some wrapping backwards
  function automatic void draw_span(output logic [63:0] t_from, output logic [63:0] t_to);
    int unsigned sel;
    t_from = {$urandom, $urandom};
    sel    = $urandom_range(0, 9);
    if (sel < 6)      t_to = t_from + 64'($urandom_range(0, 5000));
    else if (sel < 8) t_to = t_from + {32'd0, $urandom};
    else if (sel < 9) t_to = {$urandom, $urandom};
    else              t_to = t_from - 64'($urandom_range(0, 100));
  endfunction

  function automatic stats_txn_t draw_txn();
    stats_txn_t  t;
    int unsigned pick;
    pick          = $urandom_range(0, 99);
    t.opcode      = (pick < 74) ? plsm_pkg::OP_RECORD : (pick < 96) ? plsm_pkg::OP_READ :
                    (pick < 98) ? plsm_pkg::OP_CLEAR : OP_UNUSED;
    t.upstream    = 1'($urandom_range(0, 1));
    t.packet_kind = 2'($urandom_range(0, 3));
    draw_span(t.proc_start_time, t.proc_end_time);
    draw_span(t.queue_start_time, t.queue_end_time);
    draw_span(t.pool_in_time, t.pool_out_time);
    pick          = $urandom_range(0, 15);
    t.read_class  = (pick < 14) ? CLS_W'(pick % NUM_CLASSES) : CLS_W'(pick - 8);
    return t;
  endfunction

  function automatic stats_txn_t mk_txn(logic [1:0] op, logic up, logic [1:0] kind,
                                        logic [63:0] ps, logic [63:0] pe,
                                        logic [63:0] qs, logic [63:0] qe,
                                        logic [63:0] pi, logic [63:0] po,
                                        logic [CLS_W-1:0] rc);
    stats_txn_t t;
    t = '{op, up, kind, ps, pe, qs, qe, pi, po, rc};
    return t;
  endfunction

  function automatic void add_row(stats_txn_t t, bit fixed, stats_reply_t want);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = 1'b0;
    row.txn     = t;
    row.fixed   = fixed;
    row.want    = want;
    stim_table.push_back(row);
  endfunction

  function automatic void add_read(logic [CLS_W-1:0] rc, bit fixed, stats_reply_t want);
    add_row(mk_txn(plsm_pkg::OP_READ, 1'b0, plsm_pkg::KIND_DATA, '0, '0, '0, '0, '0, '0, rc),
            fixed, want);
  endfunction

  function automatic void add_cfg_row(bit v);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    stim_table.push_back(row);
  endfunction

  // Hold the payload until the block takes it, then predict the reply
  task automatic send_txn(stats_txn_t t, bit fixed, stats_reply_t want);
    stats_reply_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_opcode           <= t.opcode;
    in_upstream         <= t.upstream;
    in_packet_kind      <= t.packet_kind;
    in_proc_start_time  <= t.proc_start_time;
    in_proc_end_time    <= t.proc_end_time;
    in_queue_start_time <= t.queue_start_time;
    in_queue_end_time   <= t.queue_end_time;
    in_pool_in_time     <= t.pool_in_time;
    in_pool_out_time    <= t.pool_out_time;
    in_read_class       <= t.read_class;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_reply(t);
    replies_due.push_back(fixed ? want : predicted);
  endtask

  // Drop valid and wait until every owed reply is back and the block has settled
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_pool_enable(bit v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    pool_en_shadow  = v;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s: got 0x%08h, want 0x%08h", name, got, want));
  endtask

  // Compare every reply transaction with the oldest expectation
  always @(posedge clk) begin
    stats_reply_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("reply transaction with nothing outstanding");
      end else begin
        exp_r = replies_due.pop_front();
        check_field("sample_count", out_sample_count, exp_r.sample_count);
        check_field("min_total", out_min_total, exp_r.min_total);
        check_field("max_total", out_max_total, exp_r.max_total);
        check_field("avg_total", out_avg_total, exp_r.avg_total);
        check_field("min_queue", out_min_queue, exp_r.min_queue);
        check_field("max_queue", out_max_queue, exp_r.max_queue);
        check_field("avg_queue", out_avg_queue, exp_r.avg_queue);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stats_reply_t zero_r, empty_main, empty_pool;
    stats_txn_t   t;
    int           seg_items;

    pool_en_shadow = 1'b0;
    clear_stats();

    zero_r     = '0;
    empty_main = '{'0, EMPTY_MIN, '0, '0, EMPTY_MIN, '0, '0};
    empty_pool = '{'0, EMPTY_MIN, '0, '0, '0, '0, '0};

    // Directed table: empty reads, out-of-range classes, unused opcode, timestamp extremes
    // and wrap, every upstream packet kind, three kinds downstream, pool on, clear.
    add_read(plsm_pkg::CLS_DATA_UP, 1'b1, empty_main);
    add_read(plsm_pkg::CLS_POOL_UP, 1'b1, empty_pool);
    add_read(CLS_BAD_LO, 1'b1, zero_r);
    add_read(CLS_BAD_HI, 1'b1, zero_r);
    add_row(mk_txn(OP_UNUSED, 1'b1, plsm_pkg::KIND_DATA, '0, '1, '0, '1, '0, '1,
                   plsm_pkg::CLS_DATA_UP), 1'b1, zero_r);
    add_row(mk_txn(plsm_pkg::OP_RECORD, 1'b1, plsm_pkg::KIND_DATA, '0, '1, '1, '0, '0, '0,
                   '0), 1'b1, zero_r);
    add_row(mk_txn(plsm_pkg::OP_RECORD, 1'b1, plsm_pkg::KIND_CLOSE, '1, '0, 64'd10, 64'd10,
                   '0, '0, '0), 1'b1, zero_r);
    add_row(mk_txn(plsm_pkg::OP_RECORD, 1'b1, KIND_OPEN, 64'd500, 64'd500, '0, '1, '0, '0,
                   '0), 1'b1, zero_r);
    add_row(mk_txn(plsm_pkg::OP_RECORD, 1'b1, KIND_SPARE, 64'h1_0000_0000, 64'h2_0000_0007,
                   64'd3, 64'd40, '0, '0, '0), 1'b1, zero_r);
    add_row(mk_txn(plsm_pkg::OP_RECORD, 1'b0, KIND_OPEN, 64'd100, 64'd350, 64'd7, 64'd9,
                   '0, '0, '0), 1'b1, zero_r);
    add_row(mk_txn(plsm_pkg::OP_RECORD, 1'b0, plsm_pkg::KIND_DATA, '1, '1, '0,
                   64'hFFFF_FFFF, '0, '0, '0), 1'b1, zero_r);
    add_read(plsm_pkg::CLS_DATA_UP, 1'b0, zero_r);
    add_read(plsm_pkg::CLS_CLOSE_UP, 1'b0, zero_r);
    add_read(plsm_pkg::CLS_OPEN_UP, 1'b0, zero_r);
    add_read(plsm_pkg::CLS_DATA_DOWN, 1'b0, zero_r);
    add_read(plsm_pkg::CLS_POOL_DOWN, 1'b0, zero_r);
    add_cfg_row(1'b1);
    add_row(mk_txn(plsm_pkg::OP_RECORD, 1'b1, plsm_pkg::KIND_DATA, 64'd1, 64'd21, 64'd2,
                   64'd5, '0, '1, '0), 1'b1, zero_r);
    add_row(mk_txn(plsm_pkg::OP_RECORD, 1'b0, plsm_pkg::KIND_CLOSE, 64'd8, 64'd9, 64'd2,
                   64'd5, 64'd5, 64'd2, '0), 1'b1, zero_r);
    add_row(mk_txn(plsm_pkg::OP_RECORD, 1'b1, plsm_pkg::KIND_CLOSE, 64'd0, 64'd4, '1, '1,
                   64'd77, 64'd77, '0), 1'b1, zero_r);
    add_read(plsm_pkg::CLS_POOL_UP, 1'b0, zero_r);
    add_read(plsm_pkg::CLS_POOL_DOWN, 1'b0, zero_r);
    add_row(mk_txn(plsm_pkg::OP_CLEAR, 1'b0, plsm_pkg::KIND_DATA, '0, '0, '0, '0, '0, '0,
                   '0), 1'b1, zero_r);
    add_read(plsm_pkg::CLS_CLOSE_UP, 1'b1, empty_main);
    add_read(plsm_pkg::CLS_POOL_DOWN, 1'b1, empty_pool);

    // Hold reset, then release it
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        drain_replies();
        write_pool_enable(stim_table[i].cfg_val);
      end else begin
        send_txn(stim_table[i].txn, stim_table[i].fixed, stim_table[i].want);
      end
    end

    // Random segments: sender-light/receiver-heavy idling, then the reverse, then
    // none, each tried with pool statistics on and off. Every boundary is a full
    // drain, so the sender also pauses until nothing is outstanding.
    seg_items = RANDOM_ITEMS / SEGMENTS;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_replies();
      case (seg / 2)
        0: begin tx_idle_pct = 6;  rx_idle_pct = 70; end
        1: begin tx_idle_pct = 70; rx_idle_pct = 6;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_pool_enable((seg % 2) == 0);
      for (int n = 0; n < seg_items; n++) begin
        t = draw_txn();
        send_txn(t, 1'b0, zero_r);
      end
    end

    drain_replies();
    repeat (END_TICKS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/plsm_pkg.sv
src/plsm_div.sv
src/plsm_dpath.sv
src/plsm_ctrl.sv
src/packet_latency_stats_monitor_core.sv
sim/packet_latency_stats_monitor_core_test.sv
